### src/lftt_pkg.sv
// Package for the last-field tally table: payload structs, constants, FSM states
// and the controller/datapath command and status structs. No dependencies.
package lftt_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BYTES  = 31;
  localparam int COUNT_BITS = 32;
  localparam int SLOT_W     = $clog2(ENTRIES);
  localparam int LEN_W      = $clog2(KEY_BYTES + 1);
  localparam int USED_W     = $clog2(ENTRIES + 1);
  localparam int POS_W      = $clog2(KEY_BYTES);
  localparam int STORE_DEPTH = ENTRIES * KEY_BYTES;
  localparam int STORE_AW   = $clog2(STORE_DEPTH);

  localparam logic [7:0] CHAR_COLON   = 8'd58;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;

  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_DUMP = 1'b1;

  localparam logic [1:0] KIND_TALLIED = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_DUMP    = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic [3:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  slot;
    logic [31:0] tally;
    logic        is_new;
    logic [7:0]  name_byte;
    logic [4:0]  name_length;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch input, handle text byte, decode action
    logic copy_step;  // copy one field byte into the key store
    logic dump_rd;    // issue key store read for current dump position
    logic dump_emit;  // emit one dump byte and advance
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_copy;  // newline allocated an entry with a non-empty key
    logic start_dump;  // dump of a used entry with a non-empty key
    logic copy_done;   // final byte copied this cycle
    logic dump_done;   // final byte emitted this cycle
  } status_t;

endpackage

### src/lftt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module lftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/lftt_ctrl.sv
// Controller FSM for the last-field tally table.
// Depends on lftt_pkg.
module lftt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lftt_pkg::status_t sts,
  output lftt_pkg::cmd_t    cmd,
  output logic              busy
);
  import lftt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start && sts.start_copy) begin
          state_nxt = ST_COPY;
        end else if (start && sts.start_dump) begin
          state_nxt = ST_DUMP_RD;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_nxt   = ST_DUMP_OUT;
      end
      ST_DUMP_OUT: begin
        cmd.dump_emit = 1'b1;
        state_nxt     = sts.dump_done ? ST_IDLE : ST_DUMP_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### src/lftt_dp.sv
// Datapath: field buffer, per-entry match flags, key lengths, counts, key store RAMs.
// Depends on lftt_pkg and lftt_ram.
module lftt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lftt_pkg::in_item_t  in_item,
  input  lftt_pkg::cmd_t      cmd,
  output lftt_pkg::status_t   sts,
  output lftt_pkg::out_item_t out_item,
  output logic                out_valid
);
  import lftt_pkg::*;

  logic [7:0]            field_r [KEY_BYTES];
  logic [LEN_W-1:0]      field_len_r;
  logic [LEN_W-1:0]      field_len_nxt;
  logic                  colon_r;
  logic [ENTRIES-1:0]    match_r;   // entry still equal to the field so far
  logic [LEN_W-1:0]      klen_r [ENTRIES];
  logic [COUNT_BITS-1:0] count_r [ENTRIES];
  logic [USED_W-1:0]     used_r;

  logic [SLOT_W-1:0]     op_slot_r;
  logic [LEN_W-1:0]      op_len_r;
  logic [POS_W-1:0]      pos_r;
  out_item_t             out_r;
  logic                  out_valid_r;

  // One small key RAM per entry, all read at the same address. Outside a dump
  // the address is the next field position, so each RAM already holds the
  // byte to compare when the next key byte arrives.
  logic [ENTRIES-1:0]    ram_we;
  logic [POS_W-1:0]      ram_raddr;
  logic [7:0]            ram_rdata [ENTRIES];

  logic is_text, is_colon, is_nl, is_key;
  logic hit;
  logic [SLOT_W-1:0] hit_slot;
  logic full;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] idx;
  logic idx_used;

  assign idx      = in_item.entry_index[SLOT_W-1:0];
  assign is_text  = in_item.action == ACT_TEXT;
  assign is_colon = is_text && in_item.data_byte == CHAR_COLON;
  assign is_nl    = is_text && in_item.data_byte == CHAR_NEWLINE;
  assign is_key   = is_text && !is_colon && !is_nl && colon_r
                    && field_len_r < LEN_W'(KEY_BYTES);
  assign full     = used_r >= USED_W'(ENTRIES);
  assign new_slot = used_r[SLOT_W-1:0];
  assign idx_used = {1'b0, in_item.entry_index} < 5'(used_r);

  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (match_r[e] && USED_W'(e) < used_r && klen_r[e] == field_len_r) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(e);
      end
    end
  end

  always_comb begin
    field_len_nxt = field_len_r;
    if (cmd.accept && (is_colon || is_nl)) begin
      field_len_nxt = '0;
    end else if (cmd.accept && is_key) begin
      field_len_nxt = field_len_r + 1'b1;
    end
  end

  assign sts.start_copy = is_nl && colon_r && !hit && !full && field_len_r != '0;
  assign sts.start_dump = !is_text && idx_used && klen_r[idx] != '0;
  assign sts.copy_done  = LEN_W'(pos_r) + 1'b1 == op_len_r;
  assign sts.dump_done  = LEN_W'(pos_r) + 1'b1 == op_len_r;

  assign ram_raddr = cmd.dump_rd ? pos_r : field_len_nxt[POS_W-1:0];

  for (genvar e = 0; e < ENTRIES; e++) begin : g_store
    assign ram_we[e] = cmd.copy_step && op_slot_r == SLOT_W'(e);

    lftt_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_store (
      .clk   (clk),
      .we    (ram_we[e]),
      .waddr (pos_r),
      .wdata (field_r[pos_r]),
      .raddr (ram_raddr),
      .rdata (ram_rdata[e])
    );
  end

  // field buffer (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.accept && is_key) begin
      field_r[field_len_r[POS_W-1:0]] <= in_item.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_len_r <= '0;
      colon_r     <= 1'b0;
      match_r     <= '1;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        klen_r[e]  <= '0;
        count_r[e] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.accept) begin
        pos_r <= '0;
        if (!is_text) begin
          op_slot_r <= idx;
          op_len_r  <= klen_r[idx];
          out_valid_r          <= !sts.start_dump;
          out_r.slot           <= in_item.entry_index;
          out_r.is_new         <= 1'b0;
          out_r.name_byte      <= '0;
          out_r.last           <= 1'b1;
          if (idx_used) begin
            out_r.result_kind <= KIND_DUMP;
            out_r.tally       <= 32'(count_r[idx]);
            out_r.name_length <= '0;
          end else begin
            out_r.result_kind <= KIND_EMPTY;
            out_r.tally       <= '0;
            out_r.name_length <= '0;
          end
        end else if (is_colon) begin
          colon_r     <= 1'b1;
          field_len_r <= '0;
          match_r     <= '1;
        end else if (is_nl) begin
          colon_r     <= 1'b0;
          field_len_r <= '0;
          match_r     <= '1;
          if (colon_r) begin
            out_valid_r       <= 1'b1;
            out_r.name_byte   <= '0;
            out_r.name_length <= 5'(field_len_r);
            out_r.last        <= 1'b1;
            if (hit) begin
              if (count_r[hit_slot] != '1) begin
                count_r[hit_slot] <= count_r[hit_slot] + 1'b1;
                out_r.tally <= 32'(count_r[hit_slot] + 1'b1);
              end else begin
                out_r.tally <= 32'(count_r[hit_slot]);
              end
              out_r.result_kind <= KIND_TALLIED;
              out_r.slot        <= 4'(hit_slot);
              out_r.is_new      <= 1'b0;
            end else if (full) begin
              out_r.result_kind <= KIND_FULL;
              out_r.slot        <= '0;
              out_r.tally       <= '0;
              out_r.is_new      <= 1'b0;
            end else begin
              klen_r[new_slot]  <= field_len_r;
              count_r[new_slot] <= COUNT_BITS'(1);
              used_r            <= used_r + 1'b1;
              op_slot_r         <= new_slot;
              op_len_r          <= field_len_r;
              out_r.result_kind <= KIND_TALLIED;
              out_r.slot        <= 4'(new_slot);
              out_r.tally       <= 32'd1;
              out_r.is_new      <= 1'b1;
            end
          end
        end else if (is_key) begin
          field_len_r <= field_len_r + 1'b1;
          for (int e = 0; e < ENTRIES; e++) begin
            if (ram_rdata[e] != in_item.data_byte) begin
              match_r[e] <= 1'b0;
            end
          end
        end
      end
      if (cmd.copy_step) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.dump_emit) begin
        out_valid_r       <= 1'b1;
        out_r.result_kind <= KIND_DUMP;
        out_r.name_byte   <= ram_rdata[op_slot_r];
        out_r.name_length <= 5'(op_len_r);
        out_r.last        <= sts.dump_done;
        out_r.slot        <= 4'(op_slot_r);
        out_r.tally       <= 32'(count_r[op_slot_r]);
        out_r.is_new      <= 1'b0;
        pos_r             <= pos_r + 1'b1;
      end
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;
endmodule

### src/last_field_tally_table.sv
// Top level of the last-field tally table: joins controller and datapath.
// Depends on lftt_pkg, lftt_ctrl, lftt_dp.
//
//   channel | ports                 | handshake
//   input   | in_item               | start & !busy
//   result  | out_item              | out_strobe, one cycle, no stall
//
// Text bytes do not raise busy. A newline that allocates an entry with a
// non-empty key holds busy while the key store RAM is written one byte a
// cycle. A dump of a used entry with a non-empty key holds busy while each
// key byte is read from the RAM, then put in the output register. Reset is
// synchronous, active low; the key store needs no clearing pass.
module last_field_tally_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lftt_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output lftt_pkg::out_item_t out_item
);
  import lftt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  lftt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lftt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item),
    .out_valid (out_strobe)
  );
endmodule

### src/lftt_checker.sv
// Port-level checker for the last-field tally table, bound to the top level.
// Depends on lftt_pkg.
module lftt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lftt_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input lftt_pkg::out_item_t out_item
);
  import lftt_pkg::*;

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe) else $error("busy or strobe after reset");

  a_text_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.action == ACT_TEXT
      && in_item.data_byte != CHAR_NEWLINE |=> !busy && !out_strobe)
    else $error("plain text byte stalled or produced a result");

  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.result_kind == KIND_FULL |-> out_item.slot == '0
      && out_item.tally == '0 && out_item.last)
    else $error("table-full result malformed");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.result_kind == KIND_EMPTY |-> out_item.last
      && out_item.name_length == '0)
    else $error("empty-slot result malformed");
endmodule

bind last_field_tally_table lftt_checker u_checker (.*);

### bench/lftt_checker.sv
// Checker for the last-field tally table: watches the input and result channels,
// predicts every result from its own copy of the table and compares in order.
// Depends on lftt_pkg.
module lftt_scoreboard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  lftt_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  lftt_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count,
  output int                  results_seen
);
  import lftt_pkg::*;

  logic [7:0]  table_keys [ENTRIES][KEY_BYTES];
  logic [4:0]  table_lens [ENTRIES];
  logic [31:0] table_counts [ENTRIES];
  int          table_used;
  logic [7:0]  line_field [KEY_BYTES];
  int          line_len;
  logic        line_has_colon;
  out_item_t   awaited_results [$];

  function automatic out_item_t make_result(logic [1:0] kind, int slot_no, logic [31:0] cnt,
                                            logic fresh, logic [7:0] b, int len, logic fin);
    out_item_t r;
    r.result_kind = kind;
    r.slot        = slot_no[3:0];
    r.tally       = cnt;
    r.is_new      = fresh;
    r.name_byte   = b;
    r.name_length = len[4:0];
    r.last        = fin;
    return r;
  endfunction

  task automatic tally_line();
    int  hit;
    bool_loop: for (int e = 0; e < table_used; e++) begin
      hit = (table_lens[e] == line_len);
      for (int i = 0; i < line_len; i++)
        if (table_keys[e][i] != line_field[i]) hit = 0;
      if (hit) begin
        if (table_counts[e] != 32'hFFFF_FFFF) table_counts[e]++;
        awaited_results.push_back(make_result(KIND_TALLIED, e, table_counts[e], 1'b0, 8'd0,
                                              line_len, 1'b1));
        return;
      end
    end
    if (table_used >= ENTRIES) begin
      awaited_results.push_back(make_result(KIND_FULL, 0, 0, 1'b0, 8'd0, line_len, 1'b1));
      return;
    end
    for (int i = 0; i < line_len; i++) table_keys[table_used][i] = line_field[i];
    table_lens[table_used] = line_len[4:0];
    table_counts[table_used] = 1;
    awaited_results.push_back(make_result(KIND_TALLIED, table_used, 1, 1'b1, 8'd0,
                                          line_len, 1'b1));
    table_used++;
  endtask

  task automatic predict_transaction(in_item_t t);
    int idx;
    int len;
    idx = t.entry_index;
    if (t.action == ACT_DUMP) begin
      if (idx >= table_used) begin
        awaited_results.push_back(make_result(KIND_EMPTY, idx, 0, 1'b0, 8'd0, 0, 1'b1));
      end else begin
        len = table_lens[idx];
        if (len == 0)
          awaited_results.push_back(make_result(KIND_DUMP, idx, table_counts[idx], 1'b0,
                                                8'd0, 0, 1'b1));
        for (int i = 0; i < len; i++)
          awaited_results.push_back(make_result(KIND_DUMP, idx, table_counts[idx], 1'b0,
                                                table_keys[idx][i], len, i == len - 1));
      end
    end else if (t.data_byte == CHAR_COLON) begin
      line_has_colon = 1'b1;
      line_len = 0;
    end else if (t.data_byte == CHAR_NEWLINE) begin
      if (line_has_colon) tally_line();
      line_has_colon = 1'b0;
      line_len = 0;
    end else if (line_has_colon && line_len < KEY_BYTES) begin
      line_field[line_len] = t.data_byte;
      line_len++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) begin
        table_lens[e] = 0;
        table_counts[e] = 0;
      end
      table_used = 0;
      line_len = 0;
      line_has_colon = 1'b0;
      awaited_results.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      // Compare before predicting: a result never leaves in its own accept cycle
      if (out_strobe) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result %p", $time, out_item);
        end else begin
          want = awaited_results.pop_front();
          if (want.result_kind !== out_item.result_kind || want.slot !== out_item.slot ||
              want.tally !== out_item.tally || want.is_new !== out_item.is_new ||
              want.name_byte !== out_item.name_byte ||
              want.name_length !== out_item.name_length || want.last !== out_item.last) begin
            fail_count++;
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
          end
        end
      end
      if (start && !busy) predict_transaction(in_item);
    end
    pending_count = awaited_results.size();
  end
endmodule

### bench/testbench.sv
// Stimulus and verdict for the last-field tally table.
// Depends on lftt_pkg, last_field_tally_table and lftt_scoreboard.
module testbench;
  import lftt_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  int        fail_count, pending_count, results_seen;
  int        idle_cycles = 0;
  int        sent = 0;
  int        dumps = 0;
  logic      calm = 1'b0;

  always #6 clk = ~clk;

  last_field_tally_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  lftt_scoreboard checker_inst (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .fail_count(fail_count),
    .pending_count(pending_count), .results_seen(results_seen)
  );

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("last_field_tally_table verification failed");
      $finish;
    end
  end

  task automatic send(logic act, logic [7:0] b, logic [3:0] idx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= '{action: act, data_byte: b, entry_index: idx};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
    if (act) dumps++;
  endtask

  task automatic send_line(int n_pre, int n_key, logic [7:0] base, int spread);
    for (int i = 0; i < n_pre; i++) send(ACT_TEXT, 8'($urandom_range(97, 122)), 4'd0);
    if (n_pre >= 0) send(ACT_TEXT, CHAR_COLON, 4'd0);
    for (int i = 0; i < n_key; i++) send(ACT_TEXT, base + 8'($urandom_range(0, spread)), 4'd0);
    send(ACT_TEXT, CHAR_NEWLINE, 4'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Directed: empty key, long truncated key, bare line, unusual bytes, dumps
    send(ACT_DUMP, 8'd0, 4'd15);
    send_line(2, 0, 8'd65, 0);
    send(ACT_TEXT, CHAR_COLON, 4'd0);
    send_line(1, 33, 8'd128, 127);
    send_line(-1, 3, 8'd97, 0);
    send(ACT_TEXT, CHAR_COLON, 4'd0);
    send(ACT_TEXT, 8'd0, 4'd0);
    send(ACT_TEXT, 8'd255, 4'd0);
    send(ACT_DUMP, 8'd0, 4'd1);
    send(ACT_TEXT, 8'd13, 4'd0);
    send(ACT_TEXT, CHAR_NEWLINE, 4'd0);
    send(ACT_DUMP, 8'd0, 4'd0);
    send(ACT_DUMP, 8'd0, 4'd1);
    send(ACT_DUMP, 8'd0, 4'd2);
    // Hold off until the table has answered everything
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // Random lines from a small alphabet so keys repeat; the table fills up
    while (sent < 110) begin
      if (sent > 90) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: send(ACT_DUMP, 8'($urandom), 4'($urandom));
        1: send(ACT_TEXT, 8'($urandom), 4'($urandom));
        2: send_line($urandom_range(0, 2), $urandom_range(0, 8), 8'($urandom), 255);
        default: send_line($urandom_range(0, 2), $urandom_range(0, 2), 8'd120, 2);
      endcase
    end
    for (int i = 0; i < 16; i++) send(ACT_DUMP, 8'd0, 4'(i));
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    $display("Sent %0d transactions (%0d dumps), checked %0d results.",
             sent, dumps, results_seen);
    if (fail_count == 0 && pending_count == 0)
      $display("last_field_tally_table verification clean");
    else
      $display("last_field_tally_table verification failed");
    $finish;
  end
endmodule
